@@ rtl/core/pds_pkg.sv @@
// Package for the projectile drag step unit: widths, constants, FSM state type.
// No dependencies; used by all modules in rtl/core.
package pds_pkg;

   localparam int FracBitsDefault = 16;
   localparam int KBits           = 16;
   localparam int DtW             = 17;
   localparam int WordW           = 32;
   localparam int AccW            = 64;

   localparam logic [0:0] ReqLaunch = 1'b0;
   localparam logic [0:0] ReqStep   = 1'b1;

   localparam logic [1:0] RegDragCoeff = 2'd0;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GRAV,
      ST_GRAV_W,
      ST_SQ,
      ST_SQ_W,
      ST_SQRT,
      ST_F1,
      ST_F1_W,
      ST_F2,
      ST_F2_W,
      ST_DRAG,
      ST_DRAG_W,
      ST_POS,
      ST_POS_W,
      ST_DONE
   } state_type;

   // request to the serial multiplier
   typedef struct packed {
      logic        start;
      logic [63:0] mag_a;
      logic [63:0] mag_b;
   } mul_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] prod;
   } mul_rsp_type;

   // saturate a signed 66-bit value to 32 bits
   function automatic logic [31:0] sat32(input logic signed [65:0] v);
      logic [31:0] r;
      if (v > 66'sd2147483647) r = 32'h7FFF_FFFF;
      else if (v < -66'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // round magnitude by sh bits, ties away
   function automatic logic [63:0] rshr(input logic [63:0] m, input logic [5:0] sh);
      logic [64:0] t;
      t = {1'b0, m} + (65'd1 << (sh - 6'd1));
      return 64'(t >> sh);
   endfunction

endpackage

@@ rtl/core/pds_mul.sv @@
// Bit-serial shift-and-add multiplier, one bit of b per cycle, ending once the
// remaining bits of b are zero or all bits of b are used. Depends on pds_pkg.
module pds_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  pds_pkg::mul_req_type req,
   output pds_pkg::mul_rsp_type rsp
);
   import pds_pkg::*;

   logic [63:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;

   // advance one multiplier bit per cycle
   always_comb begin
      a_in = a_ff; b_in = b_ff; acc_in = acc_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (req.start) begin
         a_in = req.mag_a; b_in = req.mag_b; acc_in = '0;
         cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) acc_in = acc_ff + a_ff;
         a_in = a_ff << 1;
         b_in = b_ff >> 1;
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63 || b_ff[63:1] == '0) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; acc_ff <= acc_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("mul done while busy");
   assert property (@(posedge clock) disable iff (reset) req.start |=> busy_ff)
      else $error("mul start lost");
   assert property (@(posedge clock) disable iff (reset) !busy_ff |=> !done_ff || $past(req.start) == 1'b0)
      else $error("mul spurious done");
endmodule

@@ rtl/core/pds_sqrt.sv @@
// Digit-by-digit floor square root of a 64-bit value, one result bit per cycle.
// Depends on pds_pkg.
module pds_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   import pds_pkg::*;

   logic [63:0] x_ff, x_in;
   logic [31:0] r_ff, r_in;
   logic [65:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [65:0] trial, shifted;

   // take two radicand bits per cycle, decide one root bit
   always_comb begin
      x_in = x_ff; r_in = r_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      shifted = {rem_ff[63:0], x_ff[63:62]};
      trial   = {32'd0, r_ff, 2'b01};
      if (start) begin
         x_in = radicand; r_in = '0; rem_in = '0; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in = x_ff << 2;
         if (shifted >= trial) begin
            rem_in = shifted - trial;
            r_in = {r_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted;
            r_in = {r_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; r_ff <= r_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = r_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("sqrt done while busy");
   assert property (@(posedge clock) disable iff (reset) start |=> busy_ff)
      else $error("sqrt start lost");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(cnt_ff) == 6'd31)
      else $error("sqrt early done");
endmodule

@@ rtl/core/projectile_drag_step_unit.sv @@
// Top level of the projectile drag step unit: state, sequencer, handshakes.
// Depends on pds_pkg, pds_mul, pds_sqrt.
//
// Usage: configure drag_coeff over the csr_ APB port (address 0) while idle.
// Send items on req_ (tuser = req_type, tdata = time_step, ground_height,
// load_pos_x/y/z, load_vel_x/y/z). One result beat per item on rsp_
// (tdata = pos_x/y/z, vel_x/y/z, probe_x, probe_z; tuser = hit_ground).
// A launch item passes through the done state into the output register. A step
// item runs up to 12 products (7 when the speed is zero) through one
// shift-and-add multiplier that stops once the remaining multiplier bits are
// zero, and its speed through the square root unit. One item is processed at
// a time; the next item is taken the cycle after the result beat.
// The result sits in an output register; while the receiver stalls the
// result holds and no new item is taken.
// Reset clears position, velocity, remembered position, drag_coeff and all
// handshake state.
module projectile_drag_step_unit #(
   parameter int FRAC_BITS = pds_pkg::FracBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // time_step[16:0], ground_height[48:17], load_pos_x/y/z, load_vel_x/y/z, zero pad
   input  logic [247:0] req_tdata,
   // req_type
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, probe_x, probe_z
   output logic [255:0] rsp_tdata,
   // hit_ground
   output logic [0:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import pds_pkg::*;

   localparam logic [63:0] Grav = 64'((981 * (64'd1 << FRAC_BITS) + 50) / 100);
   localparam logic [5:0]  Fb   = 6'(FRAC_BITS);
   localparam logic [5:0]  Fb1  = 6'(FRAC_BITS + 1);
   localparam logic [5:0]  Kb   = 6'(KBits);

   logic [15:0] k_ff;
   logic [31:0] pos_ff [3];
   logic [31:0] vel_ff [3];
   logic [31:0] prv_ff [3];
   logic [31:0] vold_ff [3];
   logic [16:0] dt_ff;
   logic [63:0] sum_ff, f_ff;
   logic [1:0]  idx_ff, idx_in;
   logic        hit_ff;
   state_type   st_ff, st_in;
   logic        out_v_ff;
   logic [255:0] out_d_ff;
   logic        out_h_ff;

   mul_req_type mreq;
   mul_rsp_type mrsp;
   logic        sq_start, sq_done;
   logic [31:0] sq_root;
   logic [63:0] sq_rad;

   // radicand includes the last square as it completes
   assign sq_rad = sum_ff + mrsp.prod;

   pds_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));
   pds_sqrt u_sqrt (.clock(clock), .reset(reset), .start(sq_start),
                    .radicand(sq_rad), .done(sq_done), .root(sq_root));

   // config port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == RegDragCoeff) ? {16'd0, k_ff} : 32'd0;

   logic accept, cfg_wr;
   assign req_tready = (st_ff == ST_IDLE) && !out_v_ff;
   assign accept = req_tvalid && req_tready;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;

   // operand helpers
   logic [31:0] cur_v;
   logic [32:0] s_ext;
   logic [31:0] vmag;
   logic [32:0] smag;
   always_comb begin
      cur_v = vel_ff[idx_ff];
      vmag  = cur_v[31] ? 32'(-cur_v) : cur_v;
      s_ext = {cur_v[31], cur_v} + {vold_ff[idx_ff][31], vold_ff[idx_ff]};
      smag  = s_ext[32] ? 33'(-s_ext) : s_ext;
   end

   // next state
   always_comb begin
      st_in = st_ff;
      idx_in = idx_ff;
      case (st_ff)
         ST_IDLE: if (accept) st_in = (req_tuser == ReqStep) ? ST_GRAV : ST_DONE;
         ST_GRAV: st_in = ST_GRAV_W;
         ST_GRAV_W: if (mrsp.done) begin st_in = ST_SQ; idx_in = 2'd0; end
         ST_SQ: st_in = ST_SQ_W;
         ST_SQ_W: if (mrsp.done) begin
            if (idx_ff == 2'd2) st_in = ST_SQRT;
            else begin idx_in = idx_ff + 2'd1; st_in = ST_SQ; end
         end
         ST_SQRT: if (sq_done) st_in = (sq_root == '0) ? ST_POS : ST_F1;
         ST_F1: st_in = ST_F1_W;
         ST_F1_W: if (mrsp.done) st_in = ST_F2;
         ST_F2: st_in = ST_F2_W;
         ST_F2_W: if (mrsp.done) begin st_in = ST_DRAG; idx_in = 2'd0; end
         ST_DRAG: st_in = ST_DRAG_W;
         ST_DRAG_W: if (mrsp.done) begin
            if (idx_ff == 2'd2) begin st_in = ST_POS; idx_in = 2'd0; end
            else begin idx_in = idx_ff + 2'd1; st_in = ST_DRAG; end
         end
         ST_POS: st_in = ST_POS_W;
         ST_POS_W: if (mrsp.done) begin
            if (idx_ff == 2'd2) st_in = ST_DONE;
            else begin idx_in = idx_ff + 2'd1; st_in = ST_POS; end
         end
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
      if (st_ff == ST_SQRT && sq_done) idx_in = 2'd0;
   end

   // outputs to the arithmetic units
   always_comb begin
      mreq.start = 1'b0;
      mreq.mag_a = '0;
      mreq.mag_b = '0;
      sq_start = 1'b0;
      case (st_ff)
         ST_GRAV: begin mreq.start = 1'b1; mreq.mag_a = Grav; mreq.mag_b = 64'(dt_ff); end
         ST_SQ:   begin mreq.start = 1'b1; mreq.mag_a = 64'(vmag); mreq.mag_b = 64'(vmag); end
         ST_F1:   begin mreq.start = 1'b1; mreq.mag_a = 64'(sq_root); mreq.mag_b = 64'(k_ff); end
         ST_F2:   begin mreq.start = 1'b1; mreq.mag_a = f_ff; mreq.mag_b = 64'(dt_ff); end
         ST_DRAG: begin mreq.start = 1'b1; mreq.mag_a = 64'(vmag); mreq.mag_b = f_ff; end
         ST_POS:  begin mreq.start = 1'b1; mreq.mag_a = 64'(smag); mreq.mag_b = 64'(dt_ff); end
         default: begin mreq.start = 1'b0; end
      endcase
      if (st_ff == ST_SQ_W && mrsp.done && idx_ff == 2'd2) sq_start = 1'b1;
   end

   // datapath: product rounding and registers
   logic [63:0] rnd;
   logic [31:0] vy, pv;
   always_comb begin
      rnd = '0;
      case (st_ff)
         ST_GRAV_W, ST_F2_W, ST_DRAG_W: rnd = rshr(mrsp.prod, Fb);
         ST_F1_W:  rnd = rshr(mrsp.prod, Kb);
         ST_POS_W: rnd = rshr(mrsp.prod, Fb1);
         default:  rnd = mrsp.prod;
      endcase
      vy = vel_ff[1];
      pv = pos_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dt_ff <= req_tdata[16:0];
         if (req_tuser == ReqLaunch) begin
            for (int i = 0; i < 3; i++) begin
               pos_ff[i] <= req_tdata[49 + 32*i +: 32];
               prv_ff[i] <= req_tdata[49 + 32*i +: 32];
               vel_ff[i] <= req_tdata[145 + 32*i +: 32];
            end
            hit_ff <= 1'b0;
         end else begin
            hit_ff <= $signed(prv_ff[1]) < $signed(req_tdata[48:17]);
            for (int i = 0; i < 3; i++) begin
               prv_ff[i]  <= pos_ff[i];
               vold_ff[i] <= vel_ff[i];
            end
         end
      end
      if (st_ff == ST_GRAV) sum_ff <= '0;
      if (st_ff == ST_GRAV_W && mrsp.done)
         vel_ff[1] <= sat32(66'(signed'(vy)) - $signed({2'b00, rnd}));
      if (st_ff == ST_SQ_W && mrsp.done) sum_ff <= sum_ff + mrsp.prod;
      if (st_ff == ST_F1_W && mrsp.done) f_ff <= rnd;
      if (st_ff == ST_F2_W && mrsp.done) f_ff <= (rnd > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : rnd;
      if (st_ff == ST_DRAG_W && mrsp.done)
         vel_ff[idx_ff] <= cur_v[31] ?
            sat32(66'(signed'(cur_v)) + $signed({2'b00, rnd})) :
            sat32(66'(signed'(cur_v)) - $signed({2'b00, rnd}));
      if (st_ff == ST_POS_W && mrsp.done)
         pos_ff[idx_ff] <= s_ext[32] ?
            sat32(66'(signed'(pv)) - $signed({2'b00, rnd})) :
            sat32(66'(signed'(pv)) + $signed({2'b00, rnd}));
      if (st_ff == ST_DONE) begin
         out_d_ff <= {prv_ff[2], prv_ff[0], vel_ff[2], vel_ff[1], vel_ff[0],
                      pos_ff[2], pos_ff[1], pos_ff[0]};
         out_h_ff <= hit_ff;
      end
      if (reset) begin
         st_ff <= ST_IDLE; idx_ff <= '0; out_v_ff <= 1'b0; k_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0; vel_ff[i] <= '0; prv_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in; idx_ff <= idx_in;
         if (cfg_wr && csr_paddr == RegDragCoeff) k_ff <= csr_pwdata[15:0];
         if (st_ff == ST_DONE) out_v_ff <= 1'b1;
         else if (rsp_tready) out_v_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tuser  = out_h_ff;

   assert property (@(posedge clock) disable iff (reset) accept |=> st_ff != ST_IDLE)
      else $error("accepted item not started");
   assert property (@(posedge clock) disable iff (reset) (st_ff == ST_DONE) |=> out_v_ff)
      else $error("result not presented");
   assert property (@(posedge clock) disable iff (reset) out_v_ff |-> !req_tready)
      else $error("new item taken while result pending");
endmodule

@@ test/testbench.sv @@
// Testbench for projectile_drag_step_unit: directed and random launch/step beats
// checked against an in-bench fixed-point flight predictor. Needs pds_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
   import pds_pkg::*;

   localparam int WatchLimit = 20000;
   localparam int CoolCycles = 50;

   typedef struct {
      logic [0:0]         kind;
      logic [16:0]        dt;
      logic signed [31:0] ground;
      logic signed [31:0] lpos [3];
      logic signed [31:0] lvel [3];
   } flight_item;

   typedef struct {
      logic [255:0] words;
      logic         hit;
   } flight_state;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [247:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [255:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [1:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // predictor state
   logic signed [63:0] pos_m [3];
   logic signed [63:0] vel_m [3];
   logic signed [63:0] prev_m [3];
   logic [15:0]        drag_k;

   flight_state pending_q [$];
   int          fail_count;
   bit          calm;
   int          quiet_cycles;

   projectile_drag_step_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned round_shift(input longint unsigned m, input int sh);
      return (m + (64'd1 << (sh - 1))) >> sh;
   endfunction

   function automatic logic signed [63:0] scale_round(input logic signed [63:0] a,
                                                      input longint unsigned m,
                                                      input int sh);
      longint unsigned am;
      longint unsigned r;
      am = (a < 0) ? longint'(-a) : longint'(a);
      r = round_shift(am * m, sh);
      return (a < 0) ? -$signed(r) : $signed(r);
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // advance the predictor by one accepted beat and return the expected result
   function automatic flight_state predict_flight(input flight_item it);
      flight_state r;
      logic signed [63:0] vold [3];
      logic signed [63:0] gnd;
      longint unsigned grav, sumsq, speed, f, m;
      r.hit = 1'b0;
      if (it.kind == ReqLaunch) begin
         for (int i = 0; i < 3; i++) begin
            pos_m[i] = it.lpos[i];
            vel_m[i] = it.lvel[i];
            prev_m[i] = pos_m[i];
         end
      end else begin
         gnd = it.ground;
         r.hit = prev_m[1] < gnd;
         for (int i = 0; i < 3; i++) begin
            prev_m[i] = pos_m[i];
            vold[i] = vel_m[i];
         end
         grav = (64'd981 * (64'd1 << FracBitsDefault) + 64'd50) / 64'd100;
         vel_m[1] = clamp32(vel_m[1] - $signed(round_shift(grav * it.dt, FracBitsDefault)));
         sumsq = 0;
         for (int i = 0; i < 3; i++) begin
            m = (vel_m[i] < 0) ? longint'(-vel_m[i]) : longint'(vel_m[i]);
            sumsq += m * m;
         end
         speed = floor_sqrt(sumsq);
         // drag only when moving
         if (speed != 0) begin
            f = round_shift(speed * drag_k, KBits);
            f = round_shift(f * it.dt, FracBitsDefault);
            if (f > 64'hFFFF_FFFF) f = 64'hFFFF_FFFF;
            for (int i = 0; i < 3; i++)
               vel_m[i] = clamp32(vel_m[i] - scale_round(vel_m[i], f, FracBitsDefault));
         end
         // trapezoid position advance
         for (int i = 0; i < 3; i++)
            pos_m[i] = clamp32(pos_m[i] + scale_round(vel_m[i] + vold[i], it.dt,
                                                      FracBitsDefault + 1));
      end
      r.words = {prev_m[2][31:0], prev_m[0][31:0], vel_m[2][31:0], vel_m[1][31:0],
                 vel_m[0][31:0], pos_m[2][31:0], pos_m[1][31:0], pos_m[0][31:0]};
      return r;
   endfunction

   // drive one beat from the current edge until it is taken, then idle at random
   task automatic send_item(input flight_item it);
      req_tvalid <= 1'b1;
      req_tuser <= it.kind;
      req_tdata <= {7'd0, it.lvel[2], it.lvel[1], it.lvel[0], it.lpos[2], it.lpos[1],
                    it.lpos[0], it.ground, it.dt};
      do @(posedge clock); while (!req_tready);
      pending_q.push_back(predict_flight(it));
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      while (pending_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_drag(input logic [31:0] value);
      req_tvalid <= 1'b0;
      drain_results();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= RegDragCoeff;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      drag_k = value[15:0];
   endtask

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
         2: return 32'sh8000_0000 + $urandom_range(0, 3);
         default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      endcase
   endfunction

   function automatic flight_item make_launch();
      flight_item it;
      it.kind = ReqLaunch;
      it.dt = 17'($urandom_range(0, 17'h1FFFF));
      it.ground = $urandom;
      for (int i = 0; i < 3; i++) begin
         it.lpos[i] = rand_word();
         it.lvel[i] = rand_word();
      end
      return it;
   endfunction

   function automatic flight_item make_step();
      flight_item it;
      it.kind = ReqStep;
      it.dt = 17'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 17'h1FFFF)
                                              : $urandom_range(0, 65536));
      it.ground = ($urandom_range(0, 2) == 0) ? $signed($urandom)
                  : prev_m[1][31:0] + $signed($urandom_range(0, 32'h0002_0000)) - 32'sh1_0000;
      for (int i = 0; i < 3; i++) begin
         it.lpos[i] = $urandom;
         it.lvel[i] = $urandom;
      end
      return it;
   endfunction

   function automatic flight_item fixed_item(input logic [0:0] kind, input logic [16:0] dt,
                                             input logic signed [31:0] ground,
                                             input logic signed [31:0] p,
                                             input logic signed [31:0] v);
      flight_item it;
      it.kind = kind;
      it.dt = dt;
      it.ground = ground;
      for (int i = 0; i < 3; i++) begin
         it.lpos[i] = p;
         it.lvel[i] = v;
      end
      return it;
   endfunction

   // launch extremes, zero speed, hits, saturation, oversized time step
   task automatic test_directed();
      write_drag(32'h0000_8000);
      send_item(fixed_item(ReqLaunch, 17'h1FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      send_item(fixed_item(ReqStep, 17'd65536, 32'sh8000_0000, 0, 0));
      send_item(fixed_item(ReqStep, 17'h1FFFF, 32'sh7FFF_FFFF, 0, 0));
      send_item(fixed_item(ReqLaunch, 17'd0, 0, 32'sh8000_0000, 32'sh8000_0000));
      send_item(fixed_item(ReqStep, 17'd65536, 32'sh7FFF_FFFF, 0, 0));
      send_item(fixed_item(ReqStep, 17'd0, 32'sh8000_0000, 0, 0));
      // zero speed with zero time step leaves velocity untouched
      send_item(fixed_item(ReqLaunch, 17'd0, 0, 32'sh0001_0000, 0));
      send_item(fixed_item(ReqStep, 17'd0, 32'sh0001_0000, 0, 0));
      send_item(fixed_item(ReqStep, 17'd0, 32'sh0000_FFFF, 0, 0));
      send_item(fixed_item(ReqLaunch, 17'd0, 0, 32'sh0010_0000, 32'sh0005_0000));
      for (int i = 0; i < 6; i++)
         send_item(fixed_item(ReqStep, 17'd16384, 32'sh0010_8000, 0, 0));
      write_drag(32'hFFFF_FFFF);
      send_item(fixed_item(ReqLaunch, 17'd0, 0, 0, 32'sh7FFF_FFFF));
      send_item(fixed_item(ReqStep, 17'h1FFFF, 0, 0, 0));
      send_item(fixed_item(ReqStep, 17'd65536, 0, 0, 0));
      write_drag(32'd0);
      send_item(fixed_item(ReqLaunch, 17'd0, 0, 32'sh7FFF_0000, 32'sh7FFF_FFFF));
      send_item(fixed_item(ReqStep, 17'd65536, 0, 0, 0));
   endtask

   // random flights: a launch followed by a run of steps
   task automatic test_flights(input logic [31:0] drag, input int count);
      int sent;
      write_drag(drag);
      sent = 0;
      while (sent < count) begin
         send_item(make_launch());
         sent++;
         repeat ($urandom_range(1, 10)) begin
            send_item(make_step());
            sent++;
         end
      end
   endtask

   // hold ready low in random bursts
   int stall_left;
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin
      flight_state want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_q.pop_front();
            for (int i = 0; i < 8; i++)
               if (rsp_tdata[32*i +: 32] !== want.words[32*i +: 32]) begin
                  $display("%0t: word %0d expected %h actual %h", $time, i,
                           want.words[32*i +: 32], rsp_tdata[32*i +: 32]);
                  fail_count++;
               end
            if (rsp_tuser[0] !== want.hit) begin
               $display("%0t: hit_ground expected %b actual %b", $time, want.hit,
                        rsp_tuser[0]);
               fail_count++;
            end
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
         $display("projectile_drag_step_unit: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      fail_count = 0;
      calm = 1'b0;
      drag_k = 16'd0;
      for (int i = 0; i < 3; i++) begin
         pos_m[i] = 0;
         vel_m[i] = 0;
         prev_m[i] = 0;
      end
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= '0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_flights(32'd0, 170);
      test_flights(32'd65535, 170);
      test_flights($urandom_range(1, 65534), 170);
      test_flights($urandom, 170);
      calm = 1'b1;
      test_flights($urandom_range(0, 255), 170);
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (CoolCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("projectile_drag_step_unit: match");
      end else begin
         $display("projectile_drag_step_unit: mismatch");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/pds_pkg.sv
rtl/core/pds_mul.sv
rtl/core/pds_sqrt.sv
rtl/core/projectile_drag_step_unit.sv
test/testbench.sv
